@@ hdl/lfu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants for the LFU page table
// Transaction payloads, table geometry, entry layout and sequencer states.
// ----------------------------------------------------------------------------
package lfu_pkg;

    // Table geometry
    localparam int ENTRIES = 256;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int FILL_W  = $clog2(ENTRIES + 1);

    // Field widths
    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 32;
    localparam int SLOT_W  = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hffffffff;
    localparam logic [COUNT_W-1:0] COUNT_ONE = 32'd1;

    // Action codes
    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_RESET  = 1'b1;

    // Input transaction
    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] page_address;
    } req_t;

    // Result transaction
    typedef struct packed {
        logic [ADDR_W-1:0] mapped_address;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [ADDR_W-1:0] evicted_address;
    } rsp_t;

    // One table entry as held in memory
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
    } entry_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

endpackage

@@ hdl/lfu_page_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_page_table: fully associative page table with LFU replacement
// Channel    | Ports                  | Handshake
// -----------+------------------------+----------------------------------------
// request    | start, busy, request   | taken when start is high, busy is low
// result     | done, result           | one-cycle strobe, cannot be stalled
//
// Entries sit in one synchronous memory (address and use count). A request
// scans the filled entries, one read per cycle, tracking the match and the
// least-used entry, then writes back at most one entry. The scan length grows
// with the number of filled entries, as set by the single read port, and the
// block takes no new request while one is in progress.
// busy is high until the cycle the result shows; reset empties the fill count.
// ----------------------------------------------------------------------------
module lfu_page_table
    import lfu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output rsp_t result
);

    // Entry memory
    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    // Control state
    state_t            state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] issue_reg, issue_next;
    logic              pend_reg, pend_next;
    logic              done_reg, done_next;

    // Scan payload
    req_t               req_reg;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   match_idx_reg, match_idx_next;
    logic [COUNT_W-1:0] match_count_reg, match_count_next;
    logic               min_found_reg, min_found_next;
    logic [IDX_W-1:0]   min_idx_reg, min_idx_next;
    logic [COUNT_W-1:0] min_count_reg, min_count_next;
    logic [ADDR_W-1:0]  min_addr_reg, min_addr_next;
    rsp_t               result_reg, result_next;

    logic [31:0]        slot_wide;
    logic [IDX_W-1:0]   slot_idx;

    logic accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Read and write the entry memory
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if ((issue_reg == fill_reg) && !pend_reg)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Scan, compare and write back
    always_comb
    begin
        rd_en            = 1'b0;
        rd_addr          = issue_reg[IDX_W-1:0];
        wr_en            = 1'b0;
        wr_addr          = match_idx_reg;
        wr_data.addr     = req_reg.page_address;
        wr_data.count    = COUNT_ONE;
        fill_next        = fill_reg;
        issue_next       = issue_reg;
        pend_next        = 1'b0;
        pend_idx_next    = issue_reg[IDX_W-1:0];
        done_next        = 1'b0;
        found_next       = found_reg;
        match_idx_next   = match_idx_reg;
        match_count_next = match_count_reg;
        min_found_next   = min_found_reg;
        min_idx_next     = min_idx_reg;
        min_count_next   = min_count_reg;
        min_addr_next    = min_addr_reg;
        result_next      = result_reg;
        slot_idx         = '0;
        slot_wide        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                // Clear the scan trackers for a new transaction
                issue_next     = '0;
                found_next     = 1'b0;
                min_found_next = 1'b0;
            end
            ST_SCAN:
            begin
                // Issue the next read over the filled entries
                if (issue_reg < fill_reg)
                begin
                    rd_en      = 1'b1;
                    issue_next = issue_reg + FILL_W'(1);
                    pend_next  = 1'b1;
                end
                // Compare the entry read last cycle
                if (pend_reg)
                begin
                    if (rd_data_reg.addr == req_reg.page_address)
                    begin
                        found_next       = 1'b1;
                        match_idx_next   = pend_idx_reg;
                        match_count_next = rd_data_reg.count;
                    end
                    if (!min_found_reg || (rd_data_reg.count < min_count_reg))
                    begin
                        min_found_next = 1'b1;
                        min_idx_next   = pend_idx_reg;
                        min_count_next = rd_data_reg.count;
                        min_addr_next  = rd_data_reg.addr;
                    end
                end
            end
            ST_UPDATE:
            begin
                done_next                      = 1'b1;
                result_next.mapped_address     = req_reg.page_address;
                result_next.hit                = found_reg;
                result_next.evicted            = 1'b0;
                result_next.evicted_address    = '0;
                if (req_reg.action == ACT_RESET)
                begin
                    // Reset the count of a present entry
                    wr_en = found_reg;
                    if (found_reg)
                    begin
                        slot_idx = match_idx_reg;
                    end
                end
                else if (found_reg)
                begin
                    // Hit: saturating count increment
                    wr_en         = 1'b1;
                    slot_idx      = match_idx_reg;
                    wr_data.count = (match_count_reg == COUNT_MAX) ? COUNT_MAX
                                                                   : match_count_reg + COUNT_ONE;
                end
                else if (fill_reg < FILL_W'(ENTRIES))
                begin
                    // Miss with room: fill the next free slot
                    wr_en     = 1'b1;
                    wr_addr   = fill_reg[IDX_W-1:0];
                    slot_idx  = fill_reg[IDX_W-1:0];
                    fill_next = fill_reg + FILL_W'(1);
                end
                else
                begin
                    // Miss on a full table: replace the least-used entry
                    wr_en                       = 1'b1;
                    wr_addr                     = min_idx_reg;
                    slot_idx                    = min_idx_reg;
                    result_next.evicted         = 1'b1;
                    result_next.evicted_address = min_addr_reg;
                end
                slot_wide        = 32'(slot_idx);
                result_next.slot = slot_wide[SLOT_W-1:0];
            end
            default:
            begin
                issue_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            issue_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        pend_idx_reg    <= pend_idx_next;
        found_reg       <= found_next;
        match_idx_reg   <= match_idx_next;
        match_count_reg <= match_count_next;
        min_found_reg   <= min_found_next;
        min_idx_reg     <= min_idx_next;
        min_count_reg   <= min_count_next;
        min_addr_reg    <= min_addr_next;
        result_reg      <= result_next;
    end

endmodule
